/* src/emr_pkg.sv */
// Shared types and constants of the edge detector with run-length output.
// Used by every module of the block; depends on nothing else.
package emr_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int ADDR_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW          = ADDR_W + 1;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 16;
  localparam int PIX_W       = 8;
  localparam int RUN_W       = 27;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int LVL_W       = PTR_W + 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } nbr_mask_t;

  typedef struct packed {
    logic [EW-1:0]       w;
    logic [HEIGHT_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    pix_t              pix;
    logic              push;
    logic              flush;
    nbr_mask_t         mask;
  } item_b_t;

  typedef struct packed {
    logic      valid;
    logic      push;
    logic      flush;
    nbr_mask_t mask;
  } item_c_t;

  typedef struct packed {
    logic valid;
    logic push;
    logic flush;
    pix_t edge_val;
  } item_d_t;

  typedef struct packed {
    pix_t             edge_val;
    logic [RUN_W-1:0] len;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             room;
    logic [LVL_W-1:0] level;
  } q_stat_t;

endpackage

/* src/emr_ctrl.sv */
// Raster position counters: decide per beat the line-store column, the
// neighbour mask and whether an edge value is produced. Depends on emr_pkg.
module emr_ctrl import emr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    accept,
  input  logic    restart,
  input  opcode_t opcode,
  input  pix_t    pixel,
  input  geom_t   geom,
  output logic [ADDR_W-1:0] rd_addr,
  output item_b_t item_b
);

  logic [ADDR_W-1:0]   col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [EW-1:0]       drain_r, drain_nxt;
  item_b_t             item_r, item_nxt;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    item_nxt  = '0;
    if (row_r < geom.h) begin
      item_nxt.addr = col_r;
      item_nxt.pix  = pixel;
      if (accept && opcode == OP_PIXEL) begin
        item_nxt.valid = 1'b1;
        if (col_r != '0 && row_r != '0) begin
          item_nxt.push          = 1'b1;
          item_nxt.mask.top_ok   = (row_r != HEIGHT_W'(1));
          item_nxt.mask.bot_ok   = 1'b1;
          item_nxt.mask.left_ok  = ({1'b0, col_r} >= EW'(2));
          item_nxt.mask.right_ok = 1'b1;
        end else if (col_r == '0 && row_r >= HEIGHT_W'(2)) begin
          // First column of a line finishes the last pixel of the line two rows up.
          item_nxt.push          = 1'b1;
          item_nxt.mask.top_ok   = (row_r >= HEIGHT_W'(3));
          item_nxt.mask.bot_ok   = 1'b1;
          item_nxt.mask.left_ok  = 1'b1;
          item_nxt.mask.right_ok = 1'b0;
        end
        if (({1'b0, col_r} + 1'b1) >= geom.w) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        drain_nxt = '0;
      end
    end else begin
      item_nxt.addr = (drain_r < geom.w) ? drain_r[ADDR_W-1:0] : '0;
      item_nxt.pix  = '0;
      if (accept && opcode == OP_DRAIN) begin
        item_nxt.valid = 1'b1;
        if (drain_r == '0) begin
          item_nxt.push          = (geom.h >= HEIGHT_W'(2));
          item_nxt.mask.top_ok   = (geom.h >= HEIGHT_W'(3));
          item_nxt.mask.bot_ok   = 1'b1;
          item_nxt.mask.left_ok  = 1'b1;
          item_nxt.mask.right_ok = 1'b0;
        end else begin
          item_nxt.push          = 1'b1;
          item_nxt.mask.top_ok   = (geom.h >= HEIGHT_W'(2));
          item_nxt.mask.bot_ok   = 1'b0;
          item_nxt.mask.left_ok  = (drain_r >= EW'(2));
          item_nxt.mask.right_ok = (drain_r < geom.w);
        end
        if (drain_r >= geom.w) begin
          item_nxt.flush = 1'b1;
          col_nxt   = '0;
          row_nxt   = '0;
          drain_nxt = '0;
        end else begin
          drain_nxt = drain_r + 1'b1;
        end
      end
    end
    if (restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
      item_r  <= '0;
    end else begin
      if (adv || restart) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        drain_r <= drain_nxt;
      end
      if (adv) begin
        item_r <= item_nxt;
      end
    end
  end

  assign rd_addr = item_nxt.addr;
  assign item_b  = item_r;

endmodule

/* src/emr_window.sv */
// Two line stores with read-modify-write per beat, same-column forwarding
// and the 3x3 pixel window. Depends on emr_pkg.
module emr_window import emr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [ADDR_W-1:0] rd_addr,
  input  item_b_t           item_b,
  output win_t              win,
  output item_c_t           item_c
);

  pix_t    upper_mem [MAX_WIDTH];
  pix_t    lower_mem [MAX_WIDTH];
  pix_t    upper_q, lower_q;
  pix_t    fwd_top_r, fwd_mid_r;
  logic    fwd_r;
  pix_t    top, mid;
  win_t    win_r;
  item_c_t item_r;

  // A read of the column being written in the same cycle returns stale data,
  // so the values written are carried over instead.
  assign top = fwd_r ? fwd_top_r : upper_q;
  assign mid = fwd_r ? fwd_mid_r : lower_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      upper_q <= upper_mem[rd_addr];
      lower_q <= lower_mem[rd_addr];
      if (item_b.valid) begin
        upper_mem[item_b.addr] <= mid;
        lower_mem[item_b.addr] <= item_b.pix;
      end
      fwd_top_r <= mid;
      fwd_mid_r <= item_b.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 1'b0;
      win_r  <= '0;
      item_r <= '0;
    end else if (adv) begin
      fwd_r        <= item_b.valid && (rd_addr == item_b.addr);
      item_r.valid <= item_b.valid;
      item_r.push  <= item_b.push;
      item_r.flush <= item_b.flush;
      item_r.mask  <= item_b.mask;
      if (item_b.valid) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= top;
        win_r[1][2] <= mid;
        win_r[2][2] <= item_b.pix;
      end
    end
  end

  assign win    = win_r;
  assign item_c = item_r;

endmodule

/* src/emr_edge.sv */
// Largest absolute difference between the window centre and its unmasked
// neighbours, registered once. Depends on emr_pkg.
module emr_edge import emr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  win_t    win,
  input  item_c_t item_c,
  output item_d_t item_d
);

  pix_t    best;
  item_d_t item_r;

  always_comb begin
    logic ok;
    pix_t v;
    pix_t d;
    best = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok = !(r == 1 && c == 1)
             && (r != 0 || item_c.mask.top_ok)
             && (r != 2 || item_c.mask.bot_ok)
             && (c != 0 || item_c.mask.left_ok)
             && (c != 2 || item_c.mask.right_ok);
        v = win[r][c];
        d = (v > win[1][1]) ? (v - win[1][1]) : (win[1][1] - v);
        if (ok && d > best) begin
          best = d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (adv) begin
      item_r.valid    <= item_c.valid;
      item_r.push     <= item_c.push;
      item_r.flush    <= item_c.flush;
      item_r.edge_val <= best;
    end
  end

  assign item_d = item_r;

endmodule

/* src/emr_rle.sv */
// Run-length encoder of edge values and the four-entry result queue.
// Depends on emr_pkg.
module emr_rle import emr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    restart,
  input  item_d_t item_d,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res,
  output q_stat_t stat
);

  pix_t             val_r, val_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic             open_r, open_nxt;
  logic             e1_v, e2_v;
  res_t             e1, e2, wa;
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [LVL_W-1:0] level_r;
  logic [1:0]       npush;
  logic             pop;

  always_comb begin
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    e1_v     = 1'b0;
    e2_v     = 1'b0;
    e1       = '{edge_val: val_r, len: cnt_r, last: 1'b0};
    e2       = '0;
    if (adv && item_d.valid) begin
      if (item_d.push) begin
        if (open_r && item_d.edge_val == val_r && cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          // A different value, or a full counter, closes the open run.
          e1_v     = open_r;
          val_nxt  = item_d.edge_val;
          cnt_nxt  = RUN_W'(1);
          open_nxt = 1'b1;
        end
      end
      if (item_d.flush) begin
        e2_v     = open_nxt;
        e2       = '{edge_val: val_nxt, len: cnt_nxt, last: 1'b1};
        val_nxt  = '0;
        cnt_nxt  = '0;
        open_nxt = 1'b0;
      end
    end
    if (restart) begin
      val_nxt  = '0;
      cnt_nxt  = '0;
      open_nxt = 1'b0;
    end
  end

  assign wa    = e1_v ? e1 : e2;
  assign npush = {1'b0, e1_v} + {1'b0, e2_v};
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (e1_v || e2_v) begin
      fifo_r[wr_r] <= wa;
    end
    if (e1_v && e2_v) begin
      fifo_r[wr_r + 1'b1] <= e2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r   <= '0;
      cnt_r   <= '0;
      open_r  <= 1'b0;
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      val_r   <= val_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
      wr_r    <= wr_r + PTR_W'(npush);
      rd_r    <= rd_r + PTR_W'(pop);
      level_r <= level_r + LVL_W'(npush) - LVL_W'(pop);
    end
  end

  assign out_valid  = (level_r != '0);
  assign out_res    = fifo_r[rd_r];
  assign stat.room  = (level_r <= LVL_W'(FIFO_DEPTH - 2));
  assign stat.level = level_r;

endmodule

/* src/edge_max_abs_diff_rle.sv */
// Top level of the 3x3 max-abs-difference edge detector with run-length output.
// Depends on emr_pkg, emr_ctrl, emr_window, emr_edge and emr_rle.
//
//   channel | direction | payload
//   in_     | slave     | tdata[7:0] pixel_value, tuser[0] opcode
//   out_    | master    | tdata[7:0] edge_value, tdata[34:8] run_length, tlast last_run
//   cfg_    | APB slave | 0x0 image_width (12 bit), 0x4 image_height (16 bit)
//
// One input beat is taken every clock while the output queue has room; each beat does
// one read and one write of column-wise line stores, with forwarding when consecutive
// beats hit one column. Beats pass the control, window and edge registers in turn.
// in_tready drops while the four-entry output queue has fewer than two free slots.
// Synchronous reset clears counters, window, open run and queue; the line stores
// are not cleared, and no clearing pass is needed.
module edge_max_abs_diff_rle import emr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel_value
  input  logic [0:0]        in_tuser,   // [0] opcode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [7:0] edge_value, [34:8] run_length, zero above
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  geom_t               geom;
  logic                adv, accept;
  logic [ADDR_W-1:0]   rd_addr;
  item_b_t             item_b;
  item_c_t             item_c;
  item_d_t             item_d;
  win_t                win;
  res_t                out_res;
  q_stat_t             stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(7);
      height_r <= HEIGHT_W'(5);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_pwdata[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Out-of-range geometry is clamped rather than rejected.
  always_comb begin
    if (width_r < WIDTH_W'(2)) begin
      geom.w = EW'(2);
    end else if (32'(width_r) > MAX_WIDTH) begin
      geom.w = EW'(MAX_WIDTH);
    end else begin
      geom.w = EW'(width_r);
    end
    geom.h = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  assign adv       = stat.room;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  emr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .accept  (accept),
    .restart (cfg_wr),
    .opcode  (opcode_t'(in_tuser[0])),
    .pixel   (in_tdata),
    .geom    (geom),
    .rd_addr (rd_addr),
    .item_b  (item_b)
  );

  emr_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_addr (rd_addr),
    .item_b  (item_b),
    .win     (win),
    .item_c  (item_c)
  );

  emr_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .win    (win),
    .item_c (item_c),
    .item_d (item_d)
  );

  emr_rle u_rle (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .restart   (cfg_wr),
    .item_d    (item_d),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .stat      (stat)
  );

  assign out_tdata = {5'b0, out_res.len, out_res.edge_val};
  assign out_tlast = out_res.last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= LVL_W'(FIFO_DEPTH))
    else $error("result queue level above its depth");

  a_queue_growth: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stat.level <= $past(stat.level) + 2))
    else $error("result queue grew by more than two entries in a cycle");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.len != '0))
    else $error("run of zero length offered on the output");
`endif

endmodule
